@@ src/ffc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ffc_pkg;
    typedef enum logic [1:0] {
        FMT_F32  = 2'd0,
        FMT_F16  = 2'd1,
        FMT_BF16 = 2'd2,
        FMT_RSVD = 2'd3
    } fmt_t;

    localparam logic [0:0] REG_SOURCE_FORMAT = 1'b0;
    localparam logic [0:0] REG_TARGET_FORMAT = 1'b1;

    typedef struct packed {
        fmt_t src;
        fmt_t dst;
    } fmt_cfg_t;

    // f16 pattern to f32 pattern; subnormals flush to signed zero
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [4:0] e;
        logic [31:0] r;
        begin
            e = h[14:10];
            if (e == 5'd0) begin
                r = {h[15], 31'd0};
            end else if (e == 5'h1f) begin
                r = {h[15], 8'hff, h[9:0], 13'd0};
            end else begin
                r = {h[15], 8'(e) + 8'd112, h[9:0], 13'd0};
            end
            return r;
        end
    endfunction

    // f32 pattern to f16 pattern, truncating
    function automatic logic [15:0] narrow_half(input logic [31:0] x);
        logic [7:0] e;
        logic [15:0] r;
        begin
            e = x[30:23];
            if (e <= 8'd112) begin
                r = {x[31], 15'd0};
            end else if (e >= 8'd143) begin
                r = {x[31], 5'h1f, 10'd0};
            end else begin
                r = {x[31], 5'(e - 8'd112), x[22:13]};
            end
            return r;
        end
    endfunction
endpackage
`default_nettype wire

@@ src/ffc_convert.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ffc_convert (
    input  wire ffc_pkg::fmt_cfg_t cfg,
    input  wire logic [31:0]       din,
    output logic [31:0]            dout
);
    import ffc_pkg::*;

    logic [31:0] wide;
    logic [31:0] narrow;

    always_comb begin
        case (cfg.src)
            FMT_F32:  wide = din;
            FMT_F16:  wide = widen_half(din[15:0]);
            FMT_BF16: wide = {din[15:0], 16'd0};
            default:  wide = 32'd0;
        endcase
        case (cfg.dst)
            FMT_F32:  narrow = wide;
            FMT_F16:  narrow = {16'd0, narrow_half(wide)};
            FMT_BF16: narrow = {16'd0, wide[31:16]};
            default:  narrow = 32'd0;
        endcase
        if (cfg.src == FMT_RSVD || cfg.dst == FMT_RSVD) begin
            dout = 32'd0;
        end else if (cfg.src == cfg.dst) begin
            dout = (cfg.src == FMT_F32) ? din : {16'd0, din[15:0]};
        end else begin
            dout = narrow;
        end
    end
endmodule
`default_nettype wire

@@ src/float_format_converter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Float format converter: one scalar per transfer between f32, f16 and bf16
// bit patterns, source and target codes held in registers 0 and 1. 16-bit
// formats sit in the low half with the upper half zero. Narrowing truncates;
// f16 subnormals and underflow become signed zero; overflow, infinity and
// NaN into f16 become signed infinity. A reserved code gives zero bits.
// The input register and the result register form the pipeline, and one element
// per cycle is sustained while m_ready is held high; the conversion is one
// combinational pass between the two registers. Write configuration only while idle.
module float_format_converter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_element_bits,
    input  wire logic        s_last_element,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_result_bits,
    output logic             m_result_last
);
    import ffc_pkg::*;

    fmt_cfg_t    cfg_reg;
    logic        in_vld_reg, out_vld_reg;
    logic [31:0] in_bits_reg, out_bits_reg;
    logic        in_last_reg, out_last_reg;
    logic [31:0] conv_bits;
    logic        out_take, in_take;

    assign cfg_ready = 1'b1;

    // advance the result stage when empty or drained; input stage follows
    assign out_take = !out_vld_reg || m_ready;
    assign in_take  = !in_vld_reg || out_take;
    assign s_ready  = in_take;

    ffc_convert u_convert (
        .cfg  (cfg_reg),
        .din  (in_bits_reg),
        .dout (conv_bits)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '{src: FMT_F32, dst: FMT_F32};
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_SOURCE_FORMAT) cfg_reg.src <= fmt_t'(cfg_data);
                else                                cfg_reg.dst <= fmt_t'(cfg_data);
            end
            if (in_take) in_vld_reg <= s_valid;
            if (out_take) out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take && s_valid) begin
            in_bits_reg <= s_element_bits;
            in_last_reg <= s_last_element;
        end
        if (out_take && in_vld_reg) begin
            out_bits_reg <= conv_bits;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_result_bits = out_bits_reg;
    assign m_result_last = out_last_reg;

    // a stalled result must hold
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_bits))
        else $error("result changed under stall");
    // a 16-bit target never sets the upper half
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && cfg_reg.dst != FMT_F32 |-> m_result_bits[31:16] == 16'd0)
        else $error("upper half set for 16-bit target");
    // a full input stage must move on when the output drains
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_take |=> out_vld_reg)
        else $error("item lost between stages");
endmodule
`default_nettype wire

@@ tb/ffc_checker.sv @@
`timescale 1ns / 1ps
module ffc_checker
    import ffc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [31:0] s_element_bits,
    input  wire logic        s_last_element,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_result_bits,
    input  wire logic        m_result_last,
    output int               mismatch_count,
    output int               pending_count
);
    typedef struct {
        logic [31:0] bits;
        logic        last;
    } conv_result_t;

    fmt_t         cur_src;
    fmt_t         cur_dst;
    conv_result_t pending_results[$];

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  ex;
        sgn = {h[15], 31'd0};
        ex  = h[14:10];
        if (ex == 5'd0) return sgn;
        if (ex == 5'd31) return sgn | 32'h7f800000 | ({22'd0, h[9:0]} << 13);
        return sgn | ((32'(ex) + 32'd112) << 23) | ({22'd0, h[9:0]} << 13);
    endfunction

    function automatic logic [31:0] single_to_half(input logic [31:0] x);
        logic [31:0] sgn;
        int          ex;
        sgn = {16'd0, x[31], 15'd0};
        ex  = int'(x[30:23]) - 112;
        if (ex <= 0) return sgn;
        if (ex >= 31) return sgn | 32'h7c00;
        return sgn | (32'(ex) << 10) | {22'd0, x[22:13]};
    endfunction

    function automatic logic [31:0] convert_element(input fmt_t sf, input fmt_t df,
                                                    input logic [31:0] e);
        logic [31:0] wide;
        if (sf == FMT_RSVD || df == FMT_RSVD) return 32'd0;
        if (sf == df) return (sf == FMT_F32) ? e : {16'd0, e[15:0]};
        case (sf)
            FMT_F32: wide = e;
            FMT_F16: wide = half_to_single(e[15:0]);
            default: wide = {e[15:0], 16'd0};
        endcase
        case (df)
            FMT_F32: return wide;
            FMT_F16: return single_to_half(wide);
            default: return wide >> 16;
        endcase
    endfunction

    assign pending_count = pending_results.size();

    always @(posedge aclk) begin
        conv_result_t exp_r;
        if (!aresetn) begin
            cur_src <= FMT_F32;
            cur_dst <= FMT_F32;
            mismatch_count <= 0;
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SOURCE_FORMAT) cur_src <= fmt_t'(cfg_data);
                else cur_dst <= fmt_t'(cfg_data);
            end
            if (s_valid && s_ready) begin
                exp_r.bits = convert_element(cur_src, cur_dst, s_element_bits);
                exp_r.last = s_last_element;
                pending_results.push_back(exp_r);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result bits=%h last=%b", $time,
                             m_result_bits, m_result_last);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (exp_r.bits !== m_result_bits || exp_r.last !== m_result_last) begin
                        $display("%0t: mismatch expected bits=%h last=%b actual bits=%h last=%b",
                                 $time, exp_r.bits, exp_r.last, m_result_bits, m_result_last);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import ffc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 700;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [1:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_element_bits;
    logic        s_last_element;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_result_bits;
    logic        m_result_last;
    int          mismatch_count;
    int          pending_count;
    int          idle_cycles;
    int          elements_sent;
    int          settings_used;
    bit          stall_enable;
    bit          long_holdoff;

    float_format_converter u_dut (.*);

    ffc_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: count cycles without any transfer on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[float_format_converter] ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        int burst;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_holdoff) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_holdoff = 1'b0;
            end else if (stall_enable && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 19);
                m_ready <= 1'b0;
                repeat (burst) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Offer one element and hold it until the transfer.
    task automatic send_element(input logic [31:0] bits, input logic last);
        int gap;
        if (stall_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_element_bits <= bits;
        s_last_element <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        elements_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Hold the write until the transfer; the caller drops valid afterwards.
    task automatic write_reg(input logic [0:0] idx, input logic [1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_formats(input fmt_t src, input fmt_t dst);
        wait_drained();
        write_reg(REG_SOURCE_FORMAT, src);
        write_reg(REG_TARGET_FORMAT, dst);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Bias random values toward exponents at the edges of the f32 and f16 ranges.
    function automatic logic [31:0] random_element(input fmt_t src);
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v[30:23] = 8'($urandom_range(108, 116));
            1: v[30:23] = 8'($urandom_range(140, 146));
            2: v[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
            3: v[14:10] = $urandom_range(0, 1) ? 5'h1f : 5'h00;
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        logic [31:0] corners[$];
        fmt_t        src;
        fmt_t        dst;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_element_bits = '0;
        s_last_element = 1'b0;
        stall_enable = 1'b0;
        long_holdoff = 1'b0;
        idle_cycles = 0;
        elements_sent = 0;
        settings_used = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: corner patterns through every format pair, reserved codes too.
        corners = '{32'h0, 32'hffffffff, 32'h7f800000, 32'hff800000, 32'h7fc00001,
                    32'h38800000, 32'h38000000, 32'h477fe000, 32'h47800000,
                    32'h00007c00, 32'h0000fc01, 32'h000003ff, 32'hffff8000,
                    32'h00003c00, 32'hdead7bff};
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                set_formats(fmt_t'(i), fmt_t'(j));
                for (int k = 0; k < ((i == 3 || j == 3) ? 2 : corners.size()); k++)
                    send_element(corners[k], k[0]);
            end
        end

        // Random phases with idling on both sides.
        stall_enable = 1'b1;
        while (elements_sent < RANDOM_ITEMS) begin
            src = fmt_t'($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(0, 2));
            dst = fmt_t'($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(0, 2));
            set_formats(src, dst);
            if (settings_used == 20) long_holdoff = 1'b1;
            repeat ($urandom_range(20, 60)) send_element(random_element(src), $urandom_range(0, 1));
        end

        // Last stretch without idling.
        stall_enable = 1'b0;
        set_formats(FMT_F32, FMT_F16);
        repeat (100) send_element(random_element(FMT_F32), $urandom_range(0, 1));
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("Converted %0d elements over %0d format settings, reserved codes included.",
                 elements_sent, settings_used);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("[float_format_converter] OK");
        end else begin
            $display("[float_format_converter] ERROR");
        end
        $finish;
    end
endmodule
